@@ sv/vtbb_pkg.sv @@
// Shared widths, constants and payload types of the volume bar builder.
package vtbb_pkg;

    // Field widths
    localparam int PRICE_BITS  = 32;
    localparam int SUM_BITS    = 48;
    localparam int INDEX_BITS  = 32;
    localparam int VOL_BITS    = 32;
    localparam int THRESH_BITS = 48;

    // Widths of internal arithmetic
    localparam int ADD_BITS = ((SUM_BITS > VOL_BITS) ? SUM_BITS : VOL_BITS) + 1;
    localparam int CMP_BITS = (SUM_BITS > THRESH_BITS) ? SUM_BITS : THRESH_BITS;

    // Threshold after reset
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(1000000);

    // One incoming price record
    typedef struct packed {
        logic [PRICE_BITS-1:0] price_open;
        logic [PRICE_BITS-1:0] price_high;
        logic [PRICE_BITS-1:0] price_low;
        logic [PRICE_BITS-1:0] price_close;
        logic [VOL_BITS-1:0]   trade_volume;
        logic                  series_end;
    } bar_in_t;

    // One finished bar
    typedef struct packed {
        logic [PRICE_BITS-1:0] open_price;
        logic [PRICE_BITS-1:0] high_price;
        logic [PRICE_BITS-1:0] bar_low;
        logic [PRICE_BITS-1:0] close_price;
        logic [SUM_BITS-1:0]   bar_volume;
        logic [INDEX_BITS-1:0] first_index;
        logic [INDEX_BITS-1:0] last_index;
    } bar_out_t;

endpackage

@@ sv/vtbb_front.sv @@
// Front end: accepts records, folds them into the open bar and decides when it closes.
module vtbb_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  vtbb_pkg::bar_in_t                 s_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vtbb_pkg::THRESH_BITS-1:0]  cfg_wdata,
    input  logic                              q_full,
    output logic                              push,
    output vtbb_pkg::bar_out_t                push_data
);
    import vtbb_pkg::*;

    logic [THRESH_BITS-1:0] thresh_reg;
    logic [SUM_BITS-1:0]    sum_reg,   sum_next;
    logic [PRICE_BITS-1:0]  high_reg,  high_next;
    logic [PRICE_BITS-1:0]  low_reg,   low_next;
    logic [PRICE_BITS-1:0]  open_reg,  open_next;
    logic [INDEX_BITS-1:0]  start_reg, start_next;
    logic [INDEX_BITS-1:0]  pos_reg,   pos_next;
    logic                   fresh_reg, fresh_next;

    logic                   accept;
    logic [SUM_BITS-1:0]    acc_base;
    logic [ADD_BITS-1:0]    sum_wide;
    logic [SUM_BITS-1:0]    sum_sat;
    logic                   closes;
    logic [INDEX_BITS-1:0]  pos_inc;

    assign s_ready   = ~q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid & s_ready;
    assign pos_inc   = pos_reg + INDEX_BITS'(1);

    // Fold the record into the running bar
    always_comb begin
        if (fresh_reg) begin
            open_next = s_data.price_open;
            high_next = s_data.price_high;
            low_next  = s_data.price_low;
            acc_base  = '0;
        end else begin
            open_next = open_reg;
            high_next = (s_data.price_high > high_reg) ? s_data.price_high : high_reg;
            low_next  = (s_data.price_low < low_reg) ? s_data.price_low : low_reg;
            acc_base  = sum_reg;
        end
        // saturating volume sum
        sum_wide = ADD_BITS'(acc_base) + ADD_BITS'(s_data.trade_volume);
        sum_sat  = (|sum_wide[ADD_BITS-1:SUM_BITS]) ? '1 : sum_wide[SUM_BITS-1:0];
        closes   = (CMP_BITS'(sum_sat) >= CMP_BITS'(thresh_reg)) | s_data.series_end;
    end

    // Next bookkeeping state
    always_comb begin
        sum_next   = closes ? '0 : sum_sat;
        fresh_next = closes;
        pos_next   = s_data.series_end ? '0 : pos_inc;
        if (closes) begin
            start_next = s_data.series_end ? '0 : pos_inc;
        end else begin
            start_next = start_reg;
        end
    end

    // Finished bar toward the queue
    always_comb begin
        push                  = accept & closes;
        push_data.open_price  = open_next;
        push_data.high_price  = high_next;
        push_data.bar_low     = low_next;
        push_data.close_price = s_data.price_close;
        push_data.bar_volume  = sum_sat;
        push_data.first_index = start_reg;
        push_data.last_index  = pos_reg;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
            sum_reg    <= '0;
            high_reg   <= '0;
            low_reg    <= '0;
            open_reg   <= '0;
            start_reg  <= '0;
            pos_reg    <= '0;
            fresh_reg  <= 1'b1;
        end else begin
            if (cfg_valid) begin
                thresh_reg <= cfg_wdata;
            end
            if (accept) begin
                sum_reg   <= sum_next;
                high_reg  <= high_next;
                low_reg   <= low_next;
                open_reg  <= open_next;
                start_reg <= start_next;
                pos_reg   <= pos_next;
                fresh_reg <= fresh_next;
            end
        end
    end

endmodule

@@ sv/vtbb_queue.sv @@
// Short queue of finished bars between front and back end.
module vtbb_queue #(
    parameter int DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  vtbb_pkg::bar_out_t push_data,
    output logic               full,
    output logic               q_valid,
    input  logic               pop,
    output vtbb_pkg::bar_out_t q_data
);
    import vtbb_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    bar_out_t              mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg,  count_next;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_BITS'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_BITS'(1);
            2'b01:   count_next = count_reg - CNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/vtbb_back.sv @@
// Back end: output register that hands bars to the receiver.
module vtbb_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  vtbb_pkg::bar_out_t q_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output vtbb_pkg::bar_out_t m_data
);
    import vtbb_pkg::*;

    logic     valid_reg;
    bar_out_t data_reg;

    // Refill whenever the register is empty or being drained
    assign pop     = q_valid & (~valid_reg | m_ready);
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= q_data;
        end
    end

endmodule

@@ sv/volume_threshold_bar_builder.sv @@
// Volume bar builder: records in, OHLCV bars out once the volume threshold is reached.
//
// Usage:
//   s_valid/s_ready/s_data carry one price record per item. m_valid/m_ready/m_data
//   carry one finished bar. cfg_valid/cfg_ready/cfg_wdata write the 48-bit volume
//   threshold (cfg_ready is always high); write it only while the block is idle.
//   A bar closes when its saturating volume sum reaches the threshold or the record
//   is flagged series_end; a series end also restarts the record index at zero.
// Throughput: one record per cycle while the queue is not full; the fold (add, compare,
//   min/max) in the front end is combinational.
// Output path: a bar is written into the queue on the edge that accepts the record
//   that closes it, then moves on to the output register once that is empty or drained.
// Reset (aresetn low, synchronous): the threshold returns to 1000000, the open bar
//   and the index are cleared, and the queue and output register are emptied.
// Receiver stall: finished bars wait in the output register and a QUEUE_DEPTH-entry
//   queue; s_ready drops only once that queue is full, so records that do not
//   close a bar keep flowing as long as there is room.
module volume_threshold_bar_builder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  vtbb_pkg::bar_in_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output vtbb_pkg::bar_out_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vtbb_pkg::THRESH_BITS-1:0]  cfg_wdata
);
    import vtbb_pkg::*;

    logic     q_full;
    logic     push;
    bar_out_t push_data;
    logic     q_valid;
    logic     pop;
    bar_out_t q_data;

    vtbb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    vtbb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_data    (q_data)
    );

    vtbb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
